// ----- rtl/generational_handle_table_macros.svh -----
// ----------------------------------------------------------------------------
// generational handle table assertion macros
// implication checks shared by the handle table rtl
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

// same-cycle implication, silent while reset is high
`define GHT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, silent while reset is high
`define GHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg
// sizes, codes, word types and token helpers of the handle table
// ----------------------------------------------------------------------------
package ght_pkg;

   localparam int unsigned TABLE_DEPTH = 1024;
   localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
   localparam int unsigned GEN_W       = 14;
   localparam int unsigned PTR_W       = 64;
   localparam int unsigned TOKEN_W     = 32;

   localparam logic [TOKEN_W-1:0] TOKEN_TAG        = 32'h4000_0000;
   localparam logic [TOKEN_W-1:0] TOKEN_TAG_MASK   = 32'hC000_0000;
   localparam logic [TOKEN_W-1:0] TOKEN_INDEX_MASK = 32'h0000_FFFF;
   localparam logic [GEN_W-1:0]   TOKEN_GEN_MASK   = 14'h3FFF;

   // operation codes
   localparam logic [1:0] FUNC_STORE   = 2'd0;
   localparam logic [1:0] FUNC_RESOLVE = 2'd1;
   localparam logic [1:0] FUNC_RELEASE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR   = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_PASS  = 3'd1;
   localparam logic [2:0] ST_STALE = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_NULL  = 3'd4;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [GEN_W-1:0] gen_type;

   typedef struct packed {
      logic             ptr_we;
      logic             gen_we;
      idx_type          addr;
      logic             owned;
      logic [PTR_W-1:0] pointer;
      gen_type          gen;
   } slot_wr_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [TOKEN_W-1:0] token_out;
      logic [PTR_W-1:0]   pointer_out;
      logic               pointer_was_owned;
   } rsp_word_type;

   typedef struct packed {
      logic    is_token;
      idx_type idx;
      gen_type gen;
   } token_type;

   function automatic token_type parse_handle(input logic [PTR_W-1:0] v);
      token_type  t;
      logic [15:0] i;
      gen_type    g;
      i = v[15:0] & TOKEN_INDEX_MASK[15:0];
      g = v[29:16] & TOKEN_GEN_MASK;
      t.is_token = (v[63:32] == 32'd0) &&
                   ((v[31:0] & TOKEN_TAG_MASK) == TOKEN_TAG) &&
                   (i != 16'd0) && (32'(i) < TABLE_DEPTH) && (g != '0);
      t.idx = i[IDX_W-1:0];
      t.gen = g;
      return t;
   endfunction

   // round-robin successor, slot 0 is skipped
   function automatic idx_type next_slot(input idx_type a);
      return (32'(a) == TABLE_DEPTH - 1) ? idx_type'(1) : a + idx_type'(1);
   endfunction

   // generation bump, wraps past the top to 1
   function automatic gen_type next_gen(input gen_type g);
      gen_type n;
      n = g + gen_type'(1);
      return (n == '0) ? gen_type'(1) : n;
   endfunction

endpackage

// ----- rtl/ght_if.sv -----
// ----------------------------------------------------------------------------
// ght channel interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface ght_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               func;
   logic [ght_pkg::PTR_W-1:0] value;
   logic                     owned_flag;

   modport source (output valid, func, value, owned_flag, input ready);
   modport sink   (input valid, func, value, owned_flag, output ready);
endinterface

interface ght_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  status;
   logic [ght_pkg::TOKEN_W-1:0] token_out;
   logic [ght_pkg::PTR_W-1:0]   pointer_out;
   logic                        pointer_was_owned;

   modport source (output valid, status, token_out, pointer_out, pointer_was_owned,
                   input ready);
   modport sink   (input valid, status, token_out, pointer_out, pointer_was_owned,
                   output ready);
endinterface

// ----- rtl/ght_slot_store.sv -----
// ----------------------------------------------------------------------------
// ght_slot_store
// slot memories: owned mark with pointer, and generation; registered read
// ----------------------------------------------------------------------------
module ght_slot_store (
   input  logic                     clock,
   input  ght_pkg::idx_type         rd_addr,
   input  ght_pkg::slot_wr_type     wr,
   output logic [ght_pkg::PTR_W-1:0] rd_pointer,
   output logic                     rd_owned,
   output ght_pkg::gen_type         rd_gen
);

   logic [ght_pkg::PTR_W:0] ptr_mem [ght_pkg::TABLE_DEPTH];
   ght_pkg::gen_type        gen_mem [ght_pkg::TABLE_DEPTH];

   logic [ght_pkg::PTR_W:0] rd_word_ff;
   ght_pkg::gen_type        rd_gen_ff;

   always_ff @(posedge clock) begin
      if (wr.ptr_we) begin
         ptr_mem[wr.addr] <= {wr.owned, wr.pointer};
      end
      rd_word_ff <= ptr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.gen_we) begin
         gen_mem[wr.addr] <= wr.gen;
      end
      rd_gen_ff <= gen_mem[rd_addr];
   end

   assign rd_pointer = rd_word_ff[ght_pkg::PTR_W-1:0];
   assign rd_owned   = rd_word_ff[ght_pkg::PTR_W];
   assign rd_gen     = rd_gen_ff;

endmodule

// ----- rtl/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// generational handle table
// slot table handing out generation-tagged tokens for 64-bit pointers
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake      word
//   req_bus   in   valid / ready  func, value, owned_flag
//   rsp_bus   out  valid / ready  status, token_out, pointer_out, pointer_was_owned
//
// store probes from the cursor, passing over each occupied slot, at most
//   TABLE_DEPTH-1 probes; one slot memory read per cycle sets the pace
// resolve and release read the slot, then check and write back;
//   null pointers and non-tokens are answered in the accept cycle
// clear sweeps the pointer memory, generations kept
// after reset a clearing pass over pointers and generations runs before req_ready rises
// a finished word waits in the response register; one more parks in a holding
//   register and the block stalls there until the response side drains
//
module generational_handle_table (
   input  logic         clock,
   input  logic         reset,
   ght_req_if.sink      req_bus,
   ght_rsp_if.source    rsp_bus
);

`include "generational_handle_table_macros.svh"

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   localparam ght_pkg::idx_type LAST_PROBE = ght_pkg::idx_type'(ght_pkg::TABLE_DEPTH - 2);
   localparam ght_pkg::idx_type LAST_SLOT  = ght_pkg::idx_type'(ght_pkg::TABLE_DEPTH - 1);

   // control state
   logic [1:0]              state_ff, state_in;
   ght_pkg::idx_type        addr_ff, addr_in;       // slot being probed or swept
   ght_pkg::idx_type        cursor_ff, cursor_in;   // round-robin search start
   ght_pkg::idx_type        probe_ff, probe_in;     // probes done in this store
   logic                    sweep_all_ff, sweep_all_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // latched request word and results
   logic [1:0]                op_ff, op_in;
   logic [ght_pkg::PTR_W-1:0] value_ff, value_in;
   logic                      owned_ff, owned_in;
   ght_pkg::gen_type          tok_gen_ff, tok_gen_in;
   ght_pkg::rsp_word_type     pend_ff, pend_in;
   ght_pkg::rsp_word_type     rsp_word_ff, rsp_word_in;

   // slot memory port
   ght_pkg::idx_type          rd_addr;
   ght_pkg::slot_wr_type      wr;
   logic [ght_pkg::PTR_W-1:0] rd_pointer;
   logic                      rd_owned;
   ght_pkg::gen_type          rd_gen;

   ght_pkg::token_type        tok;
   ght_pkg::gen_type          new_gen;
   ght_pkg::rsp_word_type     res;
   logic                      done;
   logic                      out_free;
   logic                      slot_hit;

   ght_slot_store u_slots (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .wr         (wr),
      .rd_pointer (rd_pointer),
      .rd_owned   (rd_owned),
      .rd_gen     (rd_gen)
   );

   assign tok      = ght_pkg::parse_handle(req_bus.value);
   assign new_gen  = ght_pkg::next_gen(rd_gen);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   // live slot holding the generation named by the token
   assign slot_hit = (rd_pointer != '0) && (rd_gen == tok_gen_ff);

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cursor_in    = cursor_ff;
      probe_in     = probe_ff;
      sweep_all_in = sweep_all_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      owned_in     = owned_ff;
      tok_gen_in   = tok_gen_ff;
      pend_in      = pend_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rd_addr      = addr_ff;
      wr           = '0;
      res          = '0;
      done         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in      = req_bus.func;
               value_in   = req_bus.value;
               owned_in   = req_bus.owned_flag;
               tok_gen_in = tok.gen;
               unique case (req_bus.func)
                  ght_pkg::FUNC_STORE: begin
                     if (req_bus.value == '0) begin
                        done       = 1'b1;
                        res.status = ght_pkg::ST_NULL;
                     end else begin
                        // first probe at the cursor
                        rd_addr  = cursor_ff;
                        addr_in  = cursor_ff;
                        probe_in = '0;
                        state_in = S_CHECK;
                     end
                  end
                  ght_pkg::FUNC_RESOLVE: begin
                     if (!tok.is_token) begin
                        // not a token: hand the value straight back
                        done            = 1'b1;
                        res.status      = ght_pkg::ST_PASS;
                        res.pointer_out = req_bus.value;
                     end else begin
                        rd_addr  = tok.idx;
                        addr_in  = tok.idx;
                        state_in = S_CHECK;
                     end
                  end
                  ght_pkg::FUNC_RELEASE: begin
                     if (!tok.is_token) begin
                        done       = 1'b1;
                        res.status = ght_pkg::ST_STALE;
                     end else begin
                        rd_addr  = tok.idx;
                        addr_in  = tok.idx;
                        state_in = S_CHECK;
                     end
                  end
                  ght_pkg::FUNC_CLEAR: begin
                     // free every slot, generations stay
                     addr_in      = '0;
                     sweep_all_in = 1'b0;
                     cursor_in    = ght_pkg::idx_type'(1);
                     state_in     = S_SWEEP;
                  end
               endcase
            end
         end

         S_CHECK: begin
            unique case (op_ff)
               ght_pkg::FUNC_STORE: begin
                  cursor_in = ght_pkg::next_slot(addr_ff);
                  if (rd_pointer == '0) begin
                     // free slot: claim it under a fresh generation
                     wr.ptr_we     = 1'b1;
                     wr.gen_we     = 1'b1;
                     wr.addr       = addr_ff;
                     wr.pointer    = value_ff;
                     wr.owned      = owned_ff;
                     wr.gen        = new_gen;
                     done          = 1'b1;
                     res.status    = ght_pkg::ST_OK;
                     res.token_out = ght_pkg::TOKEN_TAG | {2'b00, new_gen, 16'(addr_ff)};
                  end else if (probe_ff == LAST_PROBE) begin
                     // cursor is back where the search began
                     done       = 1'b1;
                     res.status = ght_pkg::ST_FULL;
                  end else begin
                     probe_in = probe_ff + ght_pkg::idx_type'(1);
                     addr_in  = ght_pkg::next_slot(addr_ff);
                     rd_addr  = ght_pkg::next_slot(addr_ff);
                  end
               end
               ght_pkg::FUNC_RESOLVE: begin
                  done = 1'b1;
                  if (slot_hit) begin
                     res.pointer_out = rd_pointer;
                  end else begin
                     res.status = ght_pkg::ST_STALE;
                  end
               end
               ght_pkg::FUNC_RELEASE: begin
                  done = 1'b1;
                  if (slot_hit) begin
                     wr.ptr_we = 1'b1;
                     wr.addr   = addr_ff;
                     if (rd_owned) begin
                        // caller gets the pointer back to free
                        res.pointer_out       = rd_pointer;
                        res.pointer_was_owned = 1'b1;
                     end
                  end else begin
                     res.status = ght_pkg::ST_STALE;
                  end
               end
               ght_pkg::FUNC_CLEAR: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_SWEEP: begin
            // one slot per cycle; generations too only after reset
            wr.ptr_we = 1'b1;
            wr.gen_we = sweep_all_ff;
            wr.addr   = addr_ff;
            if (addr_ff == LAST_SLOT) begin
               if (sweep_all_ff) begin
                  state_in = S_IDLE;
               end else begin
                  done       = 1'b1;
                  res.status = ght_pkg::ST_OK;
               end
            end else begin
               addr_in = addr_ff + ght_pkg::idx_type'(1);
            end
         end

         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
      endcase

      // finished word goes out now, or parks until the response side drains
      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = res;
            state_in     = S_IDLE;
         end else begin
            pend_in  = res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         addr_ff      <= '0;
         cursor_ff    <= ght_pkg::idx_type'(1);
         probe_ff     <= '0;
         sweep_all_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cursor_ff    <= cursor_in;
         probe_ff     <= probe_in;
         sweep_all_ff <= sweep_all_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      owned_ff    <= owned_in;
      tok_gen_ff  <= tok_gen_in;
      pend_ff     <= pend_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_word_ff.status;
   assign rsp_bus.token_out         = rsp_word_ff.token_out;
   assign rsp_bus.pointer_out       = rsp_word_ff.pointer_out;
   assign rsp_bus.pointer_was_owned = rsp_word_ff.pointer_was_owned;

   // cursor never lands on slot 0 or past the table
   `GHT_ASSERT_IMP(a_cursor_range, clock, reset, 1'b1,
      (cursor_ff != '0) && (32'(cursor_ff) < ght_pkg::TABLE_DEPTH),
      "search cursor out of range")

   // a clear starts its sweep at slot 0 in the next cycle
   `GHT_ASSERT_NEXT(a_clear_sweeps, clock, reset,
      (state_ff == S_IDLE) && req_bus.valid && (req_bus.func == ght_pkg::FUNC_CLEAR),
      (state_ff == S_SWEEP) && (addr_ff == '0),
      "clear did not start a sweep")

   // tokens handed out carry the tag and a nonzero slot
   `GHT_ASSERT_IMP(a_token_form, clock, reset,
      rsp_valid_ff && (rsp_word_ff.token_out != '0),
      (rsp_word_ff.token_out[31:30] == 2'b01) && (rsp_word_ff.token_out[15:0] != 16'd0),
      "malformed token")

   // the probe count stops at a full lap
   `GHT_ASSERT_IMP(a_probe_bound, clock, reset, state_ff == S_CHECK,
      probe_ff <= LAST_PROBE, "store probed past a full lap")

   // a word only parks while the response register is occupied
   `GHT_ASSERT_IMP(a_hold_needs_full, clock, reset, state_ff == S_HOLD,
      rsp_valid_ff, "holding a word with the response register empty")

endmodule
